// ===== hdl/spcd_pkg.sv =====
// Shared types, constants and helper functions for the sphere/plate contact detector.
// Used by the channel interfaces, the shared arithmetic units and the top level.
`timescale 1ns / 1ps

package spcd_pkg;

    // General datapath value, wide enough for projected offsets and their sums.
    typedef logic signed [39:0] t_val;
    // Multiplier operand and full signed product.
    typedef logic signed [35:0] t_op;
    typedef logic signed [72:0] t_prod;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd3;

    localparam logic [30:0] CFG_RESET_VAL = 31'd65536;
    localparam t_val        ONE_Q30       = 40'sd1073741824;
    localparam logic [31:0] PI_Q30        = 32'd3373259426;
    localparam logic [47:0] AREA_MAX      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_CONT = 2'd1;
    localparam logic [1:0] STAT_NEW  = 2'd2;

    typedef struct packed {
        logic signed [31:0] sphere_x;
        logic signed [31:0] sphere_y;
        logic signed [31:0] sphere_z;
        logic signed [31:0] plate_cx;
        logic signed [31:0] plate_cy;
        logic signed [31:0] plate_cz;
        logic signed [31:0] axis_z_x;
        logic signed [31:0] axis_z_y;
        logic signed [31:0] axis_z_z;
        logic signed [31:0] axis_x_x;
        logic signed [31:0] axis_x_y;
        logic signed [31:0] axis_x_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] gap_x;
        logic signed [31:0] gap_y;
        logic signed [31:0] gap_z;
        logic signed [31:0] impact_depth;
        logic        [47:0] overlap_area;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] contact_px;
        logic signed [31:0] contact_py;
        logic signed [31:0] contact_pz;
        logic        [1:0]  contact_status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WB,
        ST_ROOT,
        ST_RWAIT,
        ST_DIV,
        ST_DWAIT,
        ST_POST,
        ST_FIN
    } t_state;

    // Micro-operations of the shared multiplier, in program order.
    typedef enum logic [5:0] {
        MOP_CY0A, MOP_CY0B, MOP_CY1A, MOP_CY1B, MOP_CY2A, MOP_CY2B,
        MOP_S0, MOP_S1, MOP_S2,
        MOP_P0, MOP_P1, MOP_P2,
        MOP_X0, MOP_X1, MOP_X2,
        MOP_Y0, MOP_Y1, MOP_Y2,
        MOP_C0A, MOP_C0B, MOP_C1A, MOP_C1B, MOP_C2A, MOP_C2B,
        MOP_Q0, MOP_Q1, MOP_Q2,
        MOP_R2, MOP_SS, MOP_AL, MOP_AH,
        MOP_K0, MOP_K1, MOP_K2
    } t_mop;

    typedef enum logic {
        DSU_SQRT,
        DSU_DIV
    } t_dsu_mode;

    typedef struct packed {
        logic      start;
        t_dsu_mode mode;
    } t_dsu_ctl;

    // Round a product scaled by 2^30 to nearest, halves away from zero.
    function automatic t_val rnd30(input t_prod p);
        logic [72:0] m;
        logic [72:0] q;
        m = p[72] ? 73'(-p) : 73'(p);
        q = (m + (73'd1 << 29)) >> 30;
        return p[72] ? -$signed(q[39:0]) : $signed(q[39:0]);
    endfunction

    function automatic t_val clampv(input t_val v, input t_val lim);
        if (v < -lim) begin
            return -lim;
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_axis(input t_val v);
        t_val c;
        c = clampv(v, ONE_Q30);
        return c[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input t_val v);
        if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end else if (v > 40'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hdl/spcd_if.sv =====
// Valid/ready channel interfaces for input items, result items and register writes.
// Depends on spcd_pkg for the payload types.
`timescale 1ns / 1ps

interface spcd_in_if import spcd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spcd_out_if import spcd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spcd_cfg_if import spcd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/spcd_mul.sv =====
// Shared signed multiplier with a registered full-width product.
// Depends on spcd_pkg for the operand and product types.
`timescale 1ns / 1ps

module spcd_mul import spcd_pkg::*; (
    input  logic  i_clk,
    input  t_op   i_a,
    input  t_op   i_b,
    output t_prod o_p
);

    logic [35:0] w_ma;
    logic [35:0] w_mb;
    logic [71:0] w_m;
    logic        w_neg;
    t_prod       r_p;

    always_comb begin
        w_ma  = i_a[35] ? 36'(-i_a) : 36'(i_a);
        w_mb  = i_b[35] ? 36'(-i_b) : 36'(i_b);
        w_m   = w_ma * w_mb;
        w_neg = i_a[35] ^ i_b[35];
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_neg ? -$signed({1'b0, w_m}) : $signed({1'b0, w_m});
    end

    assign o_p = r_p;

endmodule

// ===== hdl/spcd_dsu.sv =====
// Radix-2 iterative unit shared by the square root and the divisions.
// One compare-and-subtract per cycle. Depends on spcd_pkg.
`timescale 1ns / 1ps

module spcd_dsu import spcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dsu_ctl    i_ctl,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_res
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    t_dsu_mode   r_mode;
    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_den;

    logic [35:0] w_sh;
    logic [35:0] w_trial;
    logic        w_ge;

    always_comb begin
        if (r_mode == DSU_SQRT) begin
            w_sh    = {r_rem[33:0], r_x[63:62]};
            w_trial = {2'b00, r_q, 2'b01};
        end else begin
            w_sh    = {3'b000, r_rem[31:0], r_x[63]};
            w_trial = {4'b0000, r_den};
        end
        w_ge = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mode <= i_ctl.mode;
            r_den  <= i_den;
            r_q    <= '0;
            if (i_ctl.mode == DSU_SQRT) begin
                r_x   <= i_num;
                r_rem <= '0;
            end else begin
                r_x   <= {i_num[31:0], 32'd0};
                r_rem <= {4'b0000, i_num[63:32]};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_q   <= {r_q[30:0], w_ge};
            r_x   <= (r_mode == DSU_SQRT) ? (r_x << 2) : (r_x << 1);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_q;

endmodule

// ===== hdl/sphere_plate_contact_detect.sv =====
// Sphere against rectangular plate contact detector, top level.
// Each item runs through the shared multiplier (27 products, plus 7 on contact) and the
// radix-2 root/divide unit (a root, then three divisions unless the gap is zero).
// A new input is taken only once the previous result has been loaded for output.
// Synchronous active-low reset restores register defaults and clears the contact history.
`timescale 1ns / 1ps

module sphere_plate_contact_detect import spcd_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spcd_in_if.sink        i_in,
    spcd_out_if.source     o_out,
    spcd_cfg_if.sink       i_cfg
);

    // The area product keeps 2F fraction bits in a pi scaled by 2^30, so the
    // high half of the two-part product is shifted by F - 2 with the next bit rounding.
    localparam int AREA_SH = COORD_FRAC_BITS - 2;
    localparam int AREA_RB = COORD_FRAC_BITS - 3;

    // Configuration registers.
    logic [30:0] r_cfg_radius;
    logic [30:0] r_cfg_width;
    logic [30:0] r_cfg_length;
    logic [30:0] r_cfg_height;

    // Sequencer.
    t_state r_state, n_state;
    t_mop   r_mop;
    logic [1:0] r_didx;

    // Operand and intermediate storage for one item.
    logic signed [31:0] r_ca [3];
    logic signed [31:0] r_cb [3];
    logic signed [31:0] r_oz [3];
    logic signed [31:0] r_ox [3];
    logic signed [31:0] r_oy [3];
    logic signed [32:0] r_d  [3];
    t_val               r_p  [3];
    logic signed [31:0] r_g  [3];
    logic signed [31:0] r_dir[3];
    logic signed [31:0] r_cp [3];
    t_prod              r_acc;
    t_val               r_s;
    t_val               r_px;
    t_val               r_py;
    logic [63:0]        r_sq;
    logic [31:0]        r_len;
    t_prod              r_r2;
    logic [61:0]        r_x;
    logic               r_apos;
    logic [63:0]        r_lo;
    logic [47:0]        r_area;

    // Output side.
    logic      r_ovalid;
    t_out_item r_out;
    logic      r_touch;

    // Control strobes.
    logic     w_in_ready;
    logic     w_accept;
    logic     w_fin_load;
    t_dsu_ctl w_dsu_ctl;

    // Datapath signals.
    t_op         w_a;
    t_op         w_b;
    t_prod       w_p;
    t_val        w_rnd;
    t_prod       w_sum;
    t_val        w_r, w_hw, w_hl, w_hh, w_len, w_depth, w_k, w_sv;
    logic        w_contact;
    logic [63:0] w_mid;
    logic [63:0] w_ar;
    logic [47:0] w_area_sat;
    logic [31:0] w_gmag;
    logic [63:0] w_dsu_num;
    logic        w_dsu_done;
    logic [31:0] w_dsu_res;
    logic signed [31:0] w_dirv;
    t_out_item   w_out;

    // ------------------------------------------------------------------
    // Register writes are always accepted; an unknown index is dropped.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radius <= CFG_RESET_VAL;
            r_cfg_width  <= CFG_RESET_VAL;
            r_cfg_length <= CFG_RESET_VAL;
            r_cfg_height <= CFG_RESET_VAL;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RADIUS: r_cfg_radius <= i_cfg.data[30:0];
                CFG_WIDTH:  r_cfg_width  <= i_cfg.data[30:0];
                CFG_LENGTH: r_cfg_length <= i_cfg.data[30:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg.data[30:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units.
    // ------------------------------------------------------------------
    spcd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    spcd_dsu u_dsu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dsu_ctl),
        .i_num   (w_dsu_num),
        .i_den   (r_len),
        .o_done  (w_dsu_done),
        .o_res   (w_dsu_res)
    );

    // ------------------------------------------------------------------
    // Derived scalar quantities.
    // ------------------------------------------------------------------
    always_comb begin
        w_r       = t_val'({1'b0, r_cfg_radius});
        w_hw      = t_val'({2'b00, r_cfg_width[30:1]});
        w_hl      = t_val'({2'b00, r_cfg_length[30:1]});
        w_hh      = t_val'({2'b00, r_cfg_height[30:1]});
        w_len     = t_val'({1'b0, r_len});
        w_depth   = w_r + w_hh - w_len;
        w_contact = (w_depth > 40'sd0);
        // Distance from the sphere centre to the impact point; depth is positive here.
        w_k       = w_r - (w_depth >>> 1);
        w_sv      = w_len - w_hh;

        w_rnd = rnd30(w_p);
        w_sum = r_acc + t_prod'(w_rnd);

        // High half of the area product plus the carry-in from the low half.
        w_mid = w_p[63:0] + (r_lo >> 32);
        w_ar  = (w_mid >> AREA_SH) + ((w_mid >> AREA_RB) & 64'd1);
        w_area_sat = (w_ar > {16'd0, AREA_MAX}) ? AREA_MAX : w_ar[47:0];

        // Rounded quotient |g| * 2^30 / len for the unit direction.
        w_gmag    = r_g[r_didx][31] ? 32'(-r_g[r_didx]) : 32'(r_g[r_didx]);
        w_dsu_num = (r_state == ST_ROOT) ? r_sq
                  : (({32'd0, w_gmag} << 30) + {33'd0, r_len[31:1]});
        w_dirv    = r_g[r_didx][31] ? -$signed(w_dsu_res) : $signed(w_dsu_res);
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection by micro-operation.
    // ------------------------------------------------------------------
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_mop)
            MOP_CY0A: begin w_a = t_op'(r_oz[1]); w_b = t_op'(r_ox[2]); end
            MOP_CY0B: begin w_a = t_op'(r_oz[2]); w_b = t_op'(r_ox[1]); end
            MOP_CY1A: begin w_a = t_op'(r_oz[2]); w_b = t_op'(r_ox[0]); end
            MOP_CY1B: begin w_a = t_op'(r_oz[0]); w_b = t_op'(r_ox[2]); end
            MOP_CY2A: begin w_a = t_op'(r_oz[0]); w_b = t_op'(r_ox[1]); end
            MOP_CY2B: begin w_a = t_op'(r_oz[1]); w_b = t_op'(r_ox[0]); end
            MOP_S0:   begin w_a = t_op'(r_d[0]);  w_b = t_op'(r_oz[0]); end
            MOP_S1:   begin w_a = t_op'(r_d[1]);  w_b = t_op'(r_oz[1]); end
            MOP_S2:   begin w_a = t_op'(r_d[2]);  w_b = t_op'(r_oz[2]); end
            MOP_P0:   begin w_a = t_op'(r_s);     w_b = t_op'(r_oz[0]); end
            MOP_P1:   begin w_a = t_op'(r_s);     w_b = t_op'(r_oz[1]); end
            MOP_P2:   begin w_a = t_op'(r_s);     w_b = t_op'(r_oz[2]); end
            MOP_X0:   begin w_a = t_op'(r_p[0]);  w_b = t_op'(r_ox[0]); end
            MOP_X1:   begin w_a = t_op'(r_p[1]);  w_b = t_op'(r_ox[1]); end
            MOP_X2:   begin w_a = t_op'(r_p[2]);  w_b = t_op'(r_ox[2]); end
            MOP_Y0:   begin w_a = t_op'(r_p[0]);  w_b = t_op'(r_oy[0]); end
            MOP_Y1:   begin w_a = t_op'(r_p[1]);  w_b = t_op'(r_oy[1]); end
            MOP_Y2:   begin w_a = t_op'(r_p[2]);  w_b = t_op'(r_oy[2]); end
            MOP_C0A:  begin w_a = t_op'(r_px);    w_b = t_op'(r_ox[0]); end
            MOP_C0B:  begin w_a = t_op'(r_py);    w_b = t_op'(r_oy[0]); end
            MOP_C1A:  begin w_a = t_op'(r_px);    w_b = t_op'(r_ox[1]); end
            MOP_C1B:  begin w_a = t_op'(r_py);    w_b = t_op'(r_oy[1]); end
            MOP_C2A:  begin w_a = t_op'(r_px);    w_b = t_op'(r_ox[2]); end
            MOP_C2B:  begin w_a = t_op'(r_py);    w_b = t_op'(r_oy[2]); end
            MOP_Q0:   begin w_a = t_op'(r_g[0]);  w_b = t_op'(r_g[0]);  end
            MOP_Q1:   begin w_a = t_op'(r_g[1]);  w_b = t_op'(r_g[1]);  end
            MOP_Q2:   begin w_a = t_op'(r_g[2]);  w_b = t_op'(r_g[2]);  end
            MOP_R2:   begin w_a = t_op'(w_r);     w_b = t_op'(w_r);     end
            MOP_SS:   begin w_a = t_op'(w_sv);    w_b = t_op'(w_sv);    end
            MOP_AL: begin
                w_a = t_op'({4'd0, r_x[31:0]});
                w_b = t_op'({4'd0, PI_Q30});
            end
            MOP_AH: begin
                w_a = t_op'({6'd0, r_x[61:32]});
                w_b = t_op'({4'd0, PI_Q30});
            end
            MOP_K0:   begin w_a = t_op'(w_k);     w_b = t_op'(r_dir[0]); end
            MOP_K1:   begin w_a = t_op'(w_k);     w_b = t_op'(r_dir[1]); end
            MOP_K2:   begin w_a = t_op'(w_k);     w_b = t_op'(r_dir[2]); end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_ISSUE;
            ST_ISSUE: n_state = ST_WB;
            ST_WB: begin
                if (r_mop == MOP_Q2) begin
                    n_state = ST_ROOT;
                end else if (r_mop == MOP_K2) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ROOT:  n_state = ST_RWAIT;
            ST_RWAIT: begin
                if (w_dsu_done) begin
                    n_state = (w_dsu_res == 32'd0) ? ST_POST : ST_DIV;
                end
            end
            ST_DIV:   n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (w_dsu_done) begin
                    n_state = (r_didx == 2'd2) ? ST_POST : ST_DIV;
                end
            end
            ST_POST:  n_state = w_contact ? ST_ISSUE : ST_FIN;
            ST_FIN:   if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs.
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready     = (r_state == ST_IDLE);
        w_accept       = w_in_ready && i_in.valid;
        w_fin_load     = (r_state == ST_FIN) && (!r_ovalid || o_out.ready);
        w_dsu_ctl.start = (r_state == ST_ROOT) || (r_state == ST_DIV);
        w_dsu_ctl.mode  = (r_state == ST_ROOT) ? DSU_SQRT : DSU_DIV;
    end

    assign i_in.ready = w_in_ready;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mop    <= MOP_CY0A;
            r_didx   <= '0;
            r_ovalid <= 1'b0;
            r_touch  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_mop <= MOP_CY0A;
            end else if ((r_state == ST_WB) && (n_state == ST_ISSUE)) begin
                r_mop <= t_mop'(r_mop + 6'd1);
            end else if ((r_state == ST_POST) && w_contact) begin
                r_mop <= MOP_R2;
            end
            if (r_state == ST_RWAIT) begin
                r_didx <= '0;
            end else if ((r_state == ST_DWAIT) && w_dsu_done) begin
                r_didx <= r_didx + 2'd1;
            end
            if (w_fin_load) begin
                r_ovalid <= 1'b1;
                r_touch  <= w_contact;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers: capture, multiplier write-back, root and divisions.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ca[0] <= i_in.data.sphere_x;
            r_ca[1] <= i_in.data.sphere_y;
            r_ca[2] <= i_in.data.sphere_z;
            r_cb[0] <= i_in.data.plate_cx;
            r_cb[1] <= i_in.data.plate_cy;
            r_cb[2] <= i_in.data.plate_cz;
            r_d[0]  <= 33'(i_in.data.sphere_x) - 33'(i_in.data.plate_cx);
            r_d[1]  <= 33'(i_in.data.sphere_y) - 33'(i_in.data.plate_cy);
            r_d[2]  <= 33'(i_in.data.sphere_z) - 33'(i_in.data.plate_cz);
            r_oz[0] <= clamp_axis(t_val'(i_in.data.axis_z_x));
            r_oz[1] <= clamp_axis(t_val'(i_in.data.axis_z_y));
            r_oz[2] <= clamp_axis(t_val'(i_in.data.axis_z_z));
            r_ox[0] <= clamp_axis(t_val'(i_in.data.axis_x_x));
            r_ox[1] <= clamp_axis(t_val'(i_in.data.axis_x_y));
            r_ox[2] <= clamp_axis(t_val'(i_in.data.axis_x_z));
        end

        if (r_state == ST_WB) begin
            case (r_mop)
                // Local y axis: difference of exact products, rounded once.
                MOP_CY0A, MOP_CY1A, MOP_CY2A: r_acc <= w_p;
                MOP_CY0B: r_oy[0] <= clamp_axis(rnd30(r_acc - w_p));
                MOP_CY1B: r_oy[1] <= clamp_axis(rnd30(r_acc - w_p));
                MOP_CY2B: r_oy[2] <= clamp_axis(rnd30(r_acc - w_p));
                // Height of the sphere centre above the mid plane.
                MOP_S0: r_acc <= t_prod'(w_rnd);
                MOP_S1: r_acc <= w_sum;
                MOP_S2: r_s   <= t_val'(w_sum);
                // In-plane offset vector.
                MOP_P0: r_p[0] <= t_val'(r_d[0]) - w_rnd;
                MOP_P1: r_p[1] <= t_val'(r_d[1]) - w_rnd;
                MOP_P2: r_p[2] <= t_val'(r_d[2]) - w_rnd;
                // Local coordinates, clamped to the plate outline.
                MOP_X0, MOP_Y0: r_acc <= t_prod'(w_rnd);
                MOP_X1, MOP_Y1: r_acc <= w_sum;
                MOP_X2: r_px <= clampv(t_val'(w_sum), w_hw);
                MOP_Y2: r_py <= clampv(t_val'(w_sum), w_hl);
                // Closest plate point back in world space, minus the sphere centre.
                MOP_C0A, MOP_C1A, MOP_C2A: r_acc <= t_prod'(w_rnd);
                MOP_C0B: r_g[0] <= sat32(t_val'(w_sum) + t_val'(r_cb[0]) - t_val'(r_ca[0]));
                MOP_C1B: r_g[1] <= sat32(t_val'(w_sum) + t_val'(r_cb[1]) - t_val'(r_ca[1]));
                MOP_C2B: r_g[2] <= sat32(t_val'(w_sum) + t_val'(r_cb[2]) - t_val'(r_ca[2]));
                // Squared gap length.
                MOP_Q0: r_sq <= w_p[63:0];
                MOP_Q1, MOP_Q2: r_sq <= r_sq + w_p[63:0];
                // Area: r^2 - s^2, kept only when positive, then times pi in two halves.
                MOP_R2: r_r2 <= w_p;
                MOP_SS: begin
                    r_apos <= (r_r2 > w_p);
                    r_x    <= (r_r2 > w_p) ? 62'(r_r2 - w_p) : 62'd0;
                end
                MOP_AL: r_lo   <= w_p[63:0];
                MOP_AH: r_area <= r_apos ? w_area_sat : 48'd0;
                // Impact point along the unit direction.
                MOP_K0: r_cp[0] <= sat32(t_val'(r_ca[0]) + w_rnd);
                MOP_K1: r_cp[1] <= sat32(t_val'(r_ca[1]) + w_rnd);
                MOP_K2: r_cp[2] <= sat32(t_val'(r_ca[2]) + w_rnd);
                default: begin
                end
            endcase
        end

        if ((r_state == ST_RWAIT) && w_dsu_done) begin
            r_len <= w_dsu_res;
            // A zero gap has no direction.
            if (w_dsu_res == 32'd0) begin
                r_dir[0] <= '0;
                r_dir[1] <= '0;
                r_dir[2] <= '0;
            end
        end

        if ((r_state == ST_DWAIT) && w_dsu_done) begin
            r_dir[r_didx] <= w_dirv;
        end

        if (w_fin_load) begin
            r_out <= w_out;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly. Without contact the area, point and status read zero.
    // ------------------------------------------------------------------
    always_comb begin
        w_out.gap_x          = r_g[0];
        w_out.gap_y          = r_g[1];
        w_out.gap_z          = r_g[2];
        w_out.impact_depth   = sat32(w_depth);
        w_out.overlap_area   = w_contact ? r_area : 48'd0;
        w_out.dir_x          = r_dir[0];
        w_out.dir_y          = r_dir[1];
        w_out.dir_z          = r_dir[2];
        w_out.contact_px     = w_contact ? r_cp[0] : 32'sd0;
        w_out.contact_py     = w_contact ? r_cp[1] : 32'sd0;
        w_out.contact_pz     = w_contact ? r_cp[2] : 32'sd0;
        w_out.contact_status = !w_contact ? STAT_NONE : (r_touch ? STAT_CONT : STAT_NEW);
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

endmodule
